// ===== hw/rtl/sipt_pkg.sv =====
package sipt_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int LEVELS        = 5;
  localparam int ID_W          = 16;
  localparam int AGE_W         = 8;
  localparam int SEV_W         = 3;
  localparam int RIDX_W        = 6;
  localparam int OUT_CNT_W     = 7;

  localparam logic [SEV_W-1:0] SEV_MIN = SEV_W'(1);
  localparam logic [SEV_W-1:0] SEV_MAX = SEV_W'(LEVELS);

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_READ   = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SEV   = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
    logic [SEV_W-1:0] sev;
  } rec_t;

  // insert request towards cells and tally
  typedef struct packed {
    logic             go;
    logic [SEV_W-1:0] sev;
  } ins_req_t;

endpackage

// ===== hw/rtl/sipt_cell.sv =====
module sipt_cell
  import sipt_pkg::*;
(
  input  logic     clk,
  input  ins_req_t ins_req,
  input  rec_t     new_rec,
  input  logic     occupied,
  input  logic     prev_keep,
  input  rec_t     prev_rec,
  input  logic     read_hit,
  output logic     keep,
  output rec_t     rec,
  output rec_t     read_rec
);

  // entry stays put if it ranks at or above the new request
  assign keep = occupied && (rec.sev >= ins_req.sev);

  always_ff @(posedge clk) begin
    if (ins_req.go && !keep) begin
      rec <= prev_keep ? new_rec : prev_rec;
    end
  end

  assign read_rec = read_hit ? rec : '0;

endmodule

// ===== hw/rtl/sipt_tally.sv =====
module sipt_tally
  import sipt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  ins_req_t         ins_req,
  output logic [CNT_W-1:0] held_count,
  output logic [CNT_W-1:0] level_count [LEVELS],
  output logic [SEV_W-1:0] lowest_sev
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      for (int k = 0; k < LEVELS; k++) begin
        level_count[k] <= '0;
      end
    end else if (ins_req.go) begin
      held_count <= held_count + CNT_W'(1);
      for (int k = 0; k < LEVELS; k++) begin
        if (ins_req.sev == SEV_W'(k + 1)) begin
          level_count[k] <= level_count[k] + CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    lowest_sev = '0;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (level_count[k] != '0) begin
        lowest_sev = SEV_W'(k + 1);
      end
    end
  end

endmodule

// ===== hw/rtl/sorted_insert_priority_table.sv =====
// Sorted-insert priority table.
// Request channel: in_valid/in_stall with kind, patient_id, patient_age,
// severity and read_index. Result channel: out_valid/out_stall with status,
// fill count, read entry fields, lowest severity and five per-level counts.
// A request is taken when in_valid is high and in_stall low; one result per
// request appears in the next cycle and is held until out_stall is low.
// Throughput is one request per cycle while in_stall is low: every cell of
// the chain compares its entry to the new severity, cells that yield shift
// in the same cycle, and a read selects one cell through a one-hot AND-OR.
// in_stall is high only while a result waits under out_stall.
// Inserts with severity outside 1..5 or into a full table change nothing.
// Reset clears the fill count, the per-level counts and the result valid;
// the cell contents are not cleared and are only ever read below the fill.
module sorted_insert_priority_table
  import sipt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 kind,
  input  logic [ID_W-1:0]      patient_id,
  input  logic [AGE_W-1:0]     patient_age,
  input  logic [SEV_W-1:0]     severity,
  input  logic [RIDX_W-1:0]    read_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic [OUT_CNT_W-1:0] fill_count,
  output logic [ID_W-1:0]      entry_id,
  output logic [AGE_W-1:0]     entry_age,
  output logic [SEV_W-1:0]     entry_severity,
  output logic [SEV_W-1:0]     lowest_severity,
  output logic [OUT_CNT_W-1:0] count_level_one,
  output logic [OUT_CNT_W-1:0] count_level_two,
  output logic [OUT_CNT_W-1:0] count_level_three,
  output logic [OUT_CNT_W-1:0] count_level_four,
  output logic [OUT_CNT_W-1:0] count_level_five
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IXW   = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
  localparam int EXT_W = CNT_W + OUT_CNT_W;

  logic             accept;
  logic             sev_ok;
  logic             full;
  logic             read_ok;
  logic [IXW-1:0]   idx_ext;
  ins_req_t         ins_req;
  rec_t             new_rec;
  rec_t             read_sel;
  status_t          status_next;
  logic [CNT_W-1:0] held_count;
  logic [CNT_W-1:0] level_count [LEVELS];
  logic [OUT_CNT_W-1:0] cnt7  [LEVELS];
  logic [OUT_CNT_W-1:0] fill7;

  logic [DEPTH-1:0] keep;
  rec_t             cell_rec  [DEPTH];
  rec_t             cell_read [DEPTH];

  rec_t             entry;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign sev_ok  = (severity >= SEV_MIN) && (severity <= SEV_MAX);
  assign full    = (held_count == CNT_W'(DEPTH));
  assign idx_ext = IXW'(read_index);
  assign read_ok = idx_ext < IXW'(held_count);

  assign ins_req.go  = accept && (kind == KIND_INSERT) && sev_ok && !full;
  assign ins_req.sev = severity;
  assign new_rec     = '{id: patient_id, age: patient_age, sev: severity};

  always_comb begin
    if (kind == KIND_INSERT) begin
      if (!sev_ok) begin
        status_next = ST_BAD_SEV;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_OK;
      end
    end else begin
      status_next = read_ok ? ST_OK : ST_BAD_INDEX;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic prev_keep;
    rec_t prev_rec;
    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
      assign prev_rec  = new_rec;
    end else begin : g_body
      assign prev_keep = keep[i-1];
      assign prev_rec  = cell_rec[i-1];
    end
    sipt_cell u_cell (
      .clk       (clk),
      .ins_req   (ins_req),
      .new_rec   (new_rec),
      .occupied  (CNT_W'(i) < held_count),
      .prev_keep (prev_keep),
      .prev_rec  (prev_rec),
      .read_hit  (idx_ext == IXW'(i)),
      .keep      (keep[i]),
      .rec       (cell_rec[i]),
      .read_rec  (cell_read[i])
    );
  end

  always_comb begin
    read_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_sel = read_sel | cell_read[i];
    end
  end

  sipt_tally #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_tally (
    .clk         (clk),
    .rst         (rst),
    .ins_req     (ins_req),
    .held_count  (held_count),
    .level_count (level_count),
    .lowest_sev  (lowest_severity)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      entry  <= ((kind == KIND_READ) && read_ok) ? read_sel : '0;
    end
  end

  assign entry_id       = entry.id;
  assign entry_age      = entry.age;
  assign entry_severity = entry.sev;

  // counts only move on an accepted request, so they stay put under a stall
  always_comb begin
    logic [EXT_W-1:0] wide;
    wide  = EXT_W'(held_count);
    fill7 = wide[OUT_CNT_W-1:0];
    for (int k = 0; k < LEVELS; k++) begin
      wide    = EXT_W'(level_count[k]);
      cnt7[k] = wide[OUT_CNT_W-1:0];
    end
  end

  assign fill_count        = fill7;
  assign count_level_one   = cnt7[0];
  assign count_level_two   = cnt7[1];
  assign count_level_three = cnt7[2];
  assign count_level_four  = cnt7[3];
  assign count_level_five  = cnt7[4];

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sipt_pkg::*;

  localparam int TABLE_DEPTH    = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    id;
    logic [AGE_W-1:0]   age;
    logic [SEV_W-1:0]   sev;
    logic [RIDX_W-1:0]  idx;
  } request_t;

  typedef struct packed {
    status_t                              status;
    logic [OUT_CNT_W-1:0]                 fill;
    logic [ID_W-1:0]                      id;
    logic [AGE_W-1:0]                     age;
    logic [SEV_W-1:0]                     sev;
    logic [SEV_W-1:0]                     lowest;
    logic [LEVELS-1:0][OUT_CNT_W-1:0]     level_cnt;
  } outcome_t;

  class triage_tracker;
    rec_t     slots[TABLE_DEPTH];
    int       held;
    int       per_level[LEVELS];
    outcome_t pending_results[$];
    int       errors;
    int       status_seen[4];
    int       good_inserts;
    int       good_reads;

    function new();
      held = 0;
      errors = 0;
      good_inserts = 0;
      good_reads = 0;
      foreach (per_level[k]) per_level[k] = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function void note_request(request_t r);
      outcome_t o;
      int pos;
      o = '0;
      o.status = ST_OK;
      if (r.kind == KIND_INSERT) begin
        if (r.sev < SEV_MIN || r.sev > SEV_MAX) begin
          o.status = ST_BAD_SEV;
        end else if (held >= TABLE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          // lands behind every record of equal or higher severity
          pos = 0;
          for (int k = int'(r.sev); k <= LEVELS; k++) pos += per_level[k-1];
          for (int i = held; i > pos; i--) slots[i] = slots[i-1];
          slots[pos] = {r.id, r.age, r.sev};
          held++;
          per_level[r.sev-1]++;
          good_inserts++;
        end
      end else if (int'(r.idx) >= held) begin
        o.status = ST_BAD_INDEX;
      end else begin
        o.id  = slots[r.idx].id;
        o.age = slots[r.idx].age;
        o.sev = slots[r.idx].sev;
        good_reads++;
      end
      o.fill = OUT_CNT_W'(held);
      for (int k = 0; k < LEVELS; k++) begin
        o.level_cnt[k] = OUT_CNT_W'(per_level[k]);
        if (per_level[k] != 0 && o.lowest == 0) o.lowest = SEV_W'(k + 1);
      end
      status_seen[o.status]++;
      pending_results.push_back(o);
    endfunction

    function void compare_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(outcome_t act);
      outcome_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding", $time);
        return;
      end
      e = pending_results.pop_front();
      compare_field("status", e.status, act.status);
      compare_field("fill_count", e.fill, act.fill);
      compare_field("entry_id", e.id, act.id);
      compare_field("entry_age", e.age, act.age);
      compare_field("entry_severity", e.sev, act.sev);
      compare_field("lowest_severity", e.lowest, act.lowest);
      for (int k = 0; k < LEVELS; k++)
        compare_field($sformatf("count_level[%0d]", k + 1), e.level_cnt[k], act.level_cnt[k]);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 kind = KIND_INSERT;
  logic [ID_W-1:0]      patient_id = '0;
  logic [AGE_W-1:0]     patient_age = '0;
  logic [SEV_W-1:0]     severity = '0;
  logic [RIDX_W-1:0]    read_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           status;
  logic [OUT_CNT_W-1:0] fill_count;
  logic [ID_W-1:0]      entry_id;
  logic [AGE_W-1:0]     entry_age;
  logic [SEV_W-1:0]     entry_severity;
  logic [SEV_W-1:0]     lowest_severity;
  logic [OUT_CNT_W-1:0] count_level_one;
  logic [OUT_CNT_W-1:0] count_level_two;
  logic [OUT_CNT_W-1:0] count_level_three;
  logic [OUT_CNT_W-1:0] count_level_four;
  logic [OUT_CNT_W-1:0] count_level_five;

  triage_tracker tracker = new();

  int burst_left = 0;
  int stall_cycle = 0;
  int stall_mode = 0;
  int idle_cycles = 0;

  sorted_insert_priority_table #(.DEPTH(TABLE_DEPTH)) uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: stall behaviour changes in phases
  always @(posedge clk) begin
    if (stall_cycle == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_cycle <= $urandom_range(20, 150);
    end else begin
      stall_cycle <= stall_cycle - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_cycle[1];
    endcase
  end

  always @(posedge clk) begin : result_check
    outcome_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen.status    = status_t'(status);
      seen.fill      = fill_count;
      seen.id        = entry_id;
      seen.age       = entry_age;
      seen.sev       = entry_severity;
      seen.lowest    = lowest_severity;
      seen.level_cnt = {count_level_five, count_level_four, count_level_three,
                        count_level_two, count_level_one};
      tracker.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_request(request_t r);
    int gap;
    in_valid    <= 1'b1;
    kind        <= r.kind;
    patient_id  <= r.id;
    patient_age <= r.age;
    severity    <= r.sev;
    read_index  <= r.idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(0, 20);
    end
  endtask

  task automatic send_item(kind_t k, logic [ID_W-1:0] id, logic [AGE_W-1:0] age,
                           logic [SEV_W-1:0] sev, logic [RIDX_W-1:0] idx);
    request_t r;
    r.kind = k;
    r.id   = id;
    r.age  = age;
    r.sev  = sev;
    r.idx  = idx;
    send_request(r);
  endtask

  function automatic request_t random_request();
    request_t r;
    int roll;
    r.id   = $urandom;
    r.age  = $urandom;
    r.sev  = $urandom_range(1, 5);
    r.idx  = $urandom;
    r.kind = KIND_READ;
    roll = $urandom_range(0, 99);
    if (tracker.held < TABLE_DEPTH) begin
      if (roll < 55) begin
        r.kind = KIND_INSERT;
      end else if (roll < 63) begin
        r.kind = KIND_INSERT;
        case ($urandom_range(0, 2))
          0: r.sev = 3'd0;
          1: r.sev = 3'd6;
          default: r.sev = 3'd7;
        endcase
      end
    end else if (roll < 20) begin
      r.kind = KIND_INSERT;
      r.sev  = $urandom_range(0, 7);
    end
    if (r.kind == KIND_READ && tracker.held > 0 && $urandom_range(0, 9) < 8)
      r.idx = $urandom_range(0, tracker.held - 1);
    return r;
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty table, bad severities, every level, equal-severity ordering
    send_item(KIND_READ, 16'hffff, 8'hff, 3'd7, 6'd0);
    send_item(KIND_READ, 16'h0000, 8'h00, 3'd0, 6'd63);
    send_item(KIND_INSERT, 16'hffff, 8'hff, 3'd0, 6'd0);
    send_item(KIND_INSERT, 16'h1234, 8'h12, 3'd6, 6'd0);
    send_item(KIND_INSERT, 16'hffff, 8'hff, 3'd7, 6'd63);
    send_item(KIND_INSERT, 16'h0000, 8'h00, 3'd3, 6'd0);
    send_item(KIND_INSERT, 16'hffff, 8'hff, 3'd1, 6'd63);
    send_item(KIND_INSERT, 16'h5555, 8'haa, 3'd5, 6'd0);
    send_item(KIND_INSERT, 16'haaaa, 8'h55, 3'd3, 6'd0);
    send_item(KIND_INSERT, 16'h0002, 8'h02, 3'd2, 6'd0);
    send_item(KIND_INSERT, 16'h0004, 8'h04, 3'd4, 6'd0);
    send_item(KIND_INSERT, 16'h8001, 8'h80, 3'd5, 6'd0);
    send_item(KIND_INSERT, 16'h0101, 8'h01, 3'd1, 6'd0);
    for (int i = 0; i < 9; i++) send_item(KIND_READ, 16'hffff, 8'hff, 3'd7, 6'(i));
    send_item(KIND_READ, 16'h0000, 8'h00, 3'd0, 6'd9);
    send_item(KIND_READ, 16'h0000, 8'h00, 3'd0, 6'd63);

    for (int n = 0; n < RANDOM_ITEMS; n++) send_request(random_request());

    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Coverage: %0d accepted inserts, %0d good reads, %0d bad severities,",
             tracker.good_inserts, tracker.good_reads, tracker.status_seen[ST_BAD_SEV]);
    $display("  %0d inserts into a full table, %0d out-of-range reads; final fill %0d",
             tracker.status_seen[ST_FULL], tracker.status_seen[ST_BAD_INDEX], tracker.held);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sipt_pkg.sv
hw/rtl/sipt_cell.sv
hw/rtl/sipt_tally.sv
hw/rtl/sorted_insert_priority_table.sv
tb/sv/tb.sv
